>>> rtl/core/adjacency_matrix_graph_store_core_assert.svh
// Assertion macros for the graph store core, clocked on clk, disabled in reset.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_CORE_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define AMGS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("graph store check failed");
`define AMGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("graph store check failed");
`else
`define AMGS_ASSERT_SAME(label, ante, cons)
`define AMGS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/amgs_pkg.sv
`timescale 1ns / 1ps
package amgs_pkg;

    localparam int MaxVertices = 16;
    localparam int VertexBits  = $clog2(MaxVertices);
    localparam int CountBits   = 5;
    localparam int FuncBits    = 2;
    localparam int DataBits    = 32;
    localparam int AddrBits    = 3;

    typedef logic [VertexBits-1:0] vertex_t;
    typedef logic [CountBits-1:0]  count_t;
    typedef logic [FuncBits-1:0]   func_t;

    localparam func_t FuncAddEdge = 2'd0;
    localparam func_t FuncSucc    = 2'd1;
    localparam func_t FuncPred    = 2'd2;
    localparam func_t FuncUnused  = 2'd3;

    localparam logic RegVertexCount = 1'b0;
    localparam count_t VertexCountReset = CountBits'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic    en;
        vertex_t row;
        vertex_t col;
    } edge_wr_t;

    typedef struct packed {
        vertex_t row;
        vertex_t col;
    } edge_rd_t;

endpackage

>>> rtl/core/amgs_if.sv
`timescale 1ns / 1ps
interface amgs_req_if;
    import amgs_pkg::*;

    logic    valid;
    logic    ready;
    func_t   func;
    vertex_t from_vertex;
    vertex_t to_vertex;
    vertex_t query_vertex;

    modport source (output valid, output func, output from_vertex, output to_vertex,
                    output query_vertex, input ready);
    modport sink   (input valid, input func, input from_vertex, input to_vertex,
                    input query_vertex, output ready);
endinterface

interface amgs_rsp_if;
    import amgs_pkg::*;

    logic    valid;
    logic    ready;
    vertex_t neighbor;
    logic    found;
    logic    last;
    logic    bad_vertex;

    modport source (output valid, output neighbor, output found, output last,
                    output bad_vertex, input ready);
    modport sink   (input valid, input neighbor, input found, input last,
                    input bad_vertex, output ready);
endinterface

>>> rtl/core/amgs_edge_matrix.sv
`timescale 1ns / 1ps
module amgs_edge_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  amgs_pkg::edge_wr_t wr,
    input  amgs_pkg::edge_rd_t rd,
    output logic               rd_bit
);
    import amgs_pkg::*;

    logic [MaxVertices-1:0] rows_reg [MaxVertices];

    // row = source vertex, bit = destination vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MaxVertices; r++)
            begin
                rows_reg[r] <= '0;
            end
        end
        else if (wr.en)
        begin
            rows_reg[wr.row][wr.col] <= 1'b1;
        end
    end

    assign rd_bit = rows_reg[rd.row][rd.col];

endmodule

>>> rtl/core/adjacency_matrix_graph_store_core.sv
`timescale 1ns / 1ps
// Directed graph store on a 16 x 16 adjacency bit matrix, cleared at reset with no
// sweep. An add-edge word gives no result. A successor or predecessor query walks
// the row or column one bit per cycle, unless a hit finds the output register still
// full and stalls the scan, through the matrix's single read port; results leave
// through an output register, one per set bit in ascending order, the final one
// marked last, or one word with found clear when no bit is set. A query vertex at or
// above vertex_count gives one word with bad_vertex set. vertex_count sits at byte
// address 0 of the APB port; the count that the core uses saturates at 16.
`include "adjacency_matrix_graph_store_core_assert.svh"

module adjacency_matrix_graph_store_core (
    input  logic                             clk,
    input  logic                             rst_n,
    amgs_req_if.sink                         request,
    amgs_rsp_if.source                       result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [amgs_pkg::AddrBits-1:0]    paddr,
    input  logic [amgs_pkg::DataBits-1:0]    pwdata,
    output logic [amgs_pkg::DataBits-1:0]    prdata,
    output logic                             pready
);
    import amgs_pkg::*;

    count_t  vcount_reg;
    count_t  eff_count;
    state_t  state_reg, state_next;
    logic    pred_reg, pred_next;
    vertex_t qv_reg, qv_next;
    vertex_t idx_reg, idx_next;
    vertex_t pend_reg, pend_next;
    logic    pend_vld_reg, pend_vld_next;
    logic    bad_reg, bad_next;

    logic    ovld_reg, ovld_next;
    vertex_t onb_reg, onb_next;
    logic    ofound_reg, ofound_next;
    logic    olast_reg, olast_next;
    logic    obad_reg, obad_next;

    edge_wr_t wr;
    edge_rd_t rd;
    logic     hit;
    logic     accept;
    logic     can_load;
    logic     scan_end;
    logic     stall;

    // configuration port
    assign pready = 1'b1;
    assign prdata = DataBits'(vcount_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VertexCountReset;
        end
        else if (psel && penable && pwrite && (paddr[AddrBits-1] == RegVertexCount))
        begin
            vcount_reg <= pwdata[CountBits-1:0];
        end
    end

    assign eff_count = (vcount_reg > CountBits'(MaxVertices)) ? CountBits'(MaxVertices)
                                                              : vcount_reg;

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;
    assign can_load      = !ovld_reg || result.ready;
    assign scan_end      = ({1'b0, idx_reg} == (eff_count - CountBits'(1)));

    assign wr.en  = accept && (request.func == FuncAddEdge)
                    && ({1'b0, request.from_vertex} < eff_count)
                    && ({1'b0, request.to_vertex} < eff_count);
    assign wr.row = request.from_vertex;
    assign wr.col = request.to_vertex;

    assign rd.row = pred_reg ? idx_reg : qv_reg;
    assign rd.col = pred_reg ? qv_reg : idx_reg;

    amgs_edge_matrix u_matrix (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd     (rd),
        .rd_bit (hit)
    );

    assign stall = (state_reg == ST_SCAN) && hit && pend_vld_reg && !can_load;

    always_comb
    begin
        state_next    = state_reg;
        pred_next     = pred_reg;
        qv_next       = qv_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        bad_next      = bad_reg;
        ovld_next     = ovld_reg && !result.ready;
        onb_next      = onb_reg;
        ofound_next   = ofound_reg;
        olast_next    = olast_reg;
        obad_next     = obad_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && ((request.func == FuncSucc) || (request.func == FuncPred)))
                begin
                    pred_next     = (request.func == FuncPred);
                    qv_next       = request.query_vertex;
                    idx_next      = '0;
                    pend_vld_next = 1'b0;
                    if ({1'b0, request.query_vertex} >= eff_count)
                    begin
                        bad_next   = 1'b1;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (hit)
                    begin
                        // push the earlier hit out, keep this one until the next
                        if (pend_vld_reg)
                        begin
                            ovld_next   = 1'b1;
                            onb_next    = pend_reg;
                            ofound_next = 1'b1;
                            olast_next  = 1'b0;
                            obad_next   = 1'b0;
                        end
                        pend_next     = idx_reg;
                        pend_vld_next = 1'b1;
                    end
                    if (scan_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + VertexBits'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (can_load)
                begin
                    ovld_next   = 1'b1;
                    onb_next    = (pend_vld_reg && !bad_reg) ? pend_reg : '0;
                    ofound_next = pend_vld_reg && !bad_reg;
                    olast_next  = 1'b1;
                    obad_next   = bad_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_vld_reg <= 1'b0;
            bad_reg      <= 1'b0;
            ovld_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            bad_reg      <= bad_next;
            ovld_reg     <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pred_reg   <= pred_next;
        qv_reg     <= qv_next;
        idx_reg    <= idx_next;
        pend_reg   <= pend_next;
        onb_reg    <= onb_next;
        ofound_reg <= ofound_next;
        olast_reg  <= olast_next;
        obad_reg   <= obad_next;
    end

    assign result.valid      = ovld_reg;
    assign result.neighbor   = onb_reg;
    assign result.found      = ofound_reg;
    assign result.last       = olast_reg;
    assign result.bad_vertex = obad_reg;

    `AMGS_ASSERT_SAME(a_bad_word_shape, result.valid && result.bad_vertex,
                      result.last && !result.found)
    `AMGS_ASSERT_NEXT(a_stall_holds_scan, stall,
                      (state_reg == ST_SCAN) && $stable(idx_reg) && $stable(pend_reg))
    `AMGS_ASSERT_NEXT(a_bad_query_flush,
                      accept && (request.func != FuncAddEdge) && (request.func != FuncUnused)
                      && ({1'b0, request.query_vertex} >= eff_count),
                      (state_reg == ST_FLUSH) && bad_reg)

endmodule

>>> tb/adjacency_matrix_graph_store_core_test.sv
`timescale 1ns / 1ps
module adjacency_matrix_graph_store_core_test;
    import amgs_pkg::*;

    localparam int    SettleCycles = 24;
    localparam int    RunLimitNs   = 5_000_000;

    typedef struct packed {
        vertex_t neighbor;
        logic    found;
        logic    last;
        logic    bad_vertex;
    } neighbor_word_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [AddrBits-1:0] paddr;
    logic [DataBits-1:0] pwdata;
    logic [DataBits-1:0] prdata;
    logic                pready;

    amgs_req_if req_ch ();
    amgs_rsp_if rsp_ch ();

    adjacency_matrix_graph_store_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted graph state and register shadow
    logic [MaxVertices-1:0] edge_rows [MaxVertices];
    count_t                 count_shadow;
    neighbor_word_t         pending_neighbors [$];
    neighbor_word_t         want_word;
    int                     mismatch_count;
    int                     send_idle_pct;
    int                     recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #RunLimitNs;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic vertex_t any_vertex();
        return vertex_t'($urandom_range(MaxVertices - 1));
    endfunction

    task automatic predict_neighbor_words(input func_t f, input vertex_t src,
                                          input vertex_t dst, input vertex_t q);
        int unsigned    n;
        logic           hit;
        neighbor_word_t words [$];
        n = (count_shadow > MaxVertices) ? MaxVertices : count_shadow;
        if (f == FuncAddEdge)
        begin
            if (src < n && dst < n)
                edge_rows[src][dst] = 1'b1;
        end
        else if (f == FuncSucc || f == FuncPred)
        begin
            if (q >= n)
                words.insert(words.size(), neighbor_word_t'{neighbor: '0, found: 1'b0,
                                                            last: 1'b1, bad_vertex: 1'b1});
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    hit = (f == FuncSucc) ? edge_rows[q][i] : edge_rows[i][q];
                    if (hit)
                        words.insert(words.size(), neighbor_word_t'{neighbor: vertex_t'(i),
                                                                    found: 1'b1, last: 1'b0,
                                                                    bad_vertex: 1'b0});
                end
                if (words.size() == 0)
                    words.insert(words.size(), neighbor_word_t'{neighbor: '0, found: 1'b0,
                                                                last: 1'b1,
                                                                bad_vertex: 1'b0});
                else
                    words[words.size() - 1].last = 1'b1;
            end
            pending_neighbors = {pending_neighbors, words};
        end
    endtask

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_item(input func_t f, input vertex_t src, input vertex_t dst,
                             input vertex_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= f;
        req_ch.from_vertex  <= src;
        req_ch.to_vertex    <= dst;
        req_ch.query_vertex <= q;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_neighbor_words(f, src, dst, q);
        @(negedge clk);
    endtask

    task automatic send_query(input func_t f, input vertex_t q);
        send_item(f, any_vertex(), any_vertex(), q);
    endtask

    task automatic drop_request();
        req_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        while (pending_neighbors.size() != 0)
            @(negedge clk);
        // let a trailing add or scan finish before touching the register
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic apb_write(input count_t value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {RegVertexCount, 2'b00};
        pwdata  <= DataBits'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        count_shadow = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_read_check(input count_t want);
        logic [DataBits-1:0] got;
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {RegVertexCount, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        if (got !== DataBits'(want))
        begin
            $display("%0t: vertex_count read expected %0d actual %0d", $time, want, got);
            mismatch_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_vertex_count(input count_t value);
        drop_request();
        wait_results_drained();
        apb_write(value);
        if (value >= 1 && value <= MaxVertices)
            apb_read_check(value);
    endtask

    task automatic test_register_reset();
        apb_read_check(VertexCountReset);
    endtask

    task automatic test_empty_graph();
        send_query(FuncSucc, 4'd0);
        send_query(FuncPred, 4'd15);
        send_item(FuncUnused, 4'd15, 4'd15, 4'd15);
        drop_request();
    endtask

    task automatic test_edge_extremes();
        send_item(FuncAddEdge, 4'd0, 4'd15, any_vertex());
        send_item(FuncAddEdge, 4'd15, 4'd0, any_vertex());
        send_item(FuncAddEdge, 4'd0, 4'd0, any_vertex());
        send_item(FuncAddEdge, 4'd15, 4'd15, any_vertex());
        send_item(FuncAddEdge, 4'd3, 4'd7, any_vertex());
        send_item(FuncAddEdge, 4'd3, 4'd9, any_vertex());
        send_item(FuncAddEdge, 4'd3, 4'd7, any_vertex());
        send_query(FuncSucc, 4'd0);
        send_query(FuncSucc, 4'd15);
        send_query(FuncPred, 4'd0);
        send_query(FuncPred, 4'd15);
        send_query(FuncSucc, 4'd3);
        send_query(FuncPred, 4'd9);
        send_query(FuncSucc, 4'd7);
        drop_request();
    endtask

    task automatic test_vertex_count_limits();
        // one vertex: only the self loop on vertex zero is visible
        set_vertex_count(count_t'(1));
        send_item(FuncAddEdge, 4'd0, 4'd1, any_vertex());
        send_query(FuncSucc, 4'd0);
        send_query(FuncSucc, 4'd1);
        send_query(FuncPred, 4'd0);
        // zero vertices: every query is rejected, every add ignored
        set_vertex_count(count_t'(0));
        send_query(FuncSucc, 4'd0);
        send_item(FuncAddEdge, 4'd0, 4'd0, any_vertex());
        send_query(FuncPred, 4'd0);
        // counts above the matrix size saturate
        set_vertex_count(count_t'(31));
        send_query(FuncSucc, 4'd15);
        set_vertex_count(count_t'(17));
        send_query(FuncPred, 4'd15);
        set_vertex_count(count_t'(16));
    endtask

    task automatic test_random_traffic(input int items, input count_t count);
        int      pick;
        int      pause_at;
        vertex_t last_src;
        vertex_t last_dst;
        set_vertex_count(count);
        pause_at = $urandom_range(items / 4, 3 * items / 4);
        last_src = any_vertex();
        last_dst = any_vertex();
        for (int k = 0; k < items; k++)
        begin
            if (k == pause_at)
            begin
                drop_request();
                wait_results_drained();
            end
            pick = $urandom_range(99);
            if (pick < 52)
            begin
                last_src = any_vertex();
                last_dst = any_vertex();
                send_item(FuncAddEdge, last_src, last_dst, any_vertex());
            end
            else if (pick < 92)
                send_query(($urandom_range(1)) ? FuncSucc : FuncPred, any_vertex());
            else if (pick < 96)
                send_item(FuncUnused, any_vertex(), any_vertex(), any_vertex());
            else
                send_item(FuncAddEdge, last_src, last_dst, any_vertex());
        end
        drop_request();
    endtask

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_neighbors.size() == 0)
            begin
                $display("%0t: unexpected word expected none actual n=%0d f=%0b l=%0b b=%0b",
                         $time, rsp_ch.neighbor, rsp_ch.found, rsp_ch.last,
                         rsp_ch.bad_vertex);
                mismatch_count++;
            end
            else
            begin
                want_word = pending_neighbors.pop_front();
                if (rsp_ch.neighbor !== want_word.neighbor)
                begin
                    $display("%0t: neighbor expected %0d actual %0d", $time,
                             want_word.neighbor, rsp_ch.neighbor);
                    mismatch_count++;
                end
                if (rsp_ch.found !== want_word.found)
                begin
                    $display("%0t: found expected %0b actual %0b", $time,
                             want_word.found, rsp_ch.found);
                    mismatch_count++;
                end
                if (rsp_ch.last !== want_word.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             want_word.last, rsp_ch.last);
                    mismatch_count++;
                end
                if (rsp_ch.bad_vertex !== want_word.bad_vertex)
                begin
                    $display("%0t: bad_vertex expected %0b actual %0b", $time,
                             want_word.bad_vertex, rsp_ch.bad_vertex);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.func         = FuncAddEdge;
        req_ch.from_vertex  = '0;
        req_ch.to_vertex    = '0;
        req_ch.query_vertex = '0;
        mismatch_count      = 0;
        count_shadow        = VertexCountReset;
        foreach (edge_rows[i])
            edge_rows[i] = '0;
        send_idle_pct = 6;
        recv_idle_pct = 83;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_reset();
        test_empty_graph();
        test_edge_extremes();
        test_vertex_count_limits();
        test_random_traffic(105, count_t'(16));

        send_idle_pct = 83;
        recv_idle_pct = 6;
        test_random_traffic(105, count_t'($urandom_range(1, MaxVertices - 1)));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(100, count_t'(16));

        wait_results_drained();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/amgs_pkg.sv
rtl/core/amgs_if.sv
rtl/core/amgs_edge_matrix.sv
rtl/core/adjacency_matrix_graph_store_core.sv
tb/adjacency_matrix_graph_store_core_test.sv
